// ===== src/following_error_supervisor_core_macros.svh =====
// ----------------------------------------------------------------------------
// Following error supervisor: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FOLLOWING_ERROR_SUPERVISOR_CORE_MACROS_SVH
`define FOLLOWING_ERROR_SUPERVISOR_CORE_MACROS_SVH

// Same-cycle implication
`define FES_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fes_pkg.sv =====
// ----------------------------------------------------------------------------
// Following error supervisor package
// Command, state and output codes, timer constants and shared structs.
// ----------------------------------------------------------------------------
package fes_pkg;

    // Commands
    localparam logic [2:0] CMD_EVALUATE    = 3'd0;
    localparam logic [2:0] CMD_BEGIN_MOVE  = 3'd1;
    localparam logic [2:0] CMD_BEGIN_HOLD  = 3'd2;
    localparam logic [2:0] CMD_GO_IDLE     = 3'd3;
    localparam logic [2:0] CMD_CLEAR_FAULT = 3'd4;

    // Supervisor states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MOVING   = 3'd1;
    localparam logic [2:0] ST_HOLDING  = 3'd2;
    localparam logic [2:0] ST_RECOVERY = 3'd3;
    localparam logic [2:0] ST_FAULT    = 3'd4;

    // Control modes
    localparam logic [1:0] MODE_OPEN_LOOP  = 2'd0;
    localparam logic [1:0] MODE_SPEED_TRIM = 2'd2;

    // Actions and tiers
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_SOFT   = 2'd1;
    localparam logic [1:0] ACT_HARD   = 2'd2;
    localparam logic [1:0] TIER_OBSERVE = 2'd0;
    localparam logic [1:0] TIER_RECOVER = 2'd1;
    localparam logic [1:0] TIER_FAULT   = 2'd2;

    // Config register indexes
    localparam logic [2:0] REG_HARD_LIMIT    = 3'd0;
    localparam logic [2:0] REG_MOVE_ERROR    = 3'd1;
    localparam logic [2:0] REG_HOLD_ERROR    = 3'd2;
    localparam logic [2:0] REG_MOVE_TIME     = 3'd3;
    localparam logic [2:0] REG_HOLD_TIME     = 3'd4;
    localparam logic [2:0] REG_RECOVERY_TIME = 3'd5;
    localparam logic [2:0] REG_MAX_RETRIES   = 3'd6;

    // Time keeping: microseconds held as milliseconds plus remainder
    localparam logic [10:0] US_PER_MS      = 11'd1000;
    localparam logic [22:0] TMR_MS_MAX     = 23'd4294967;  // (2^32-1) / 1000
    localparam logic [9:0]  TMR_REM_MAX    = 10'd295;      // (2^32-1) % 1000
    localparam logic [16:0] RECOVERY_MS_DEF = 17'd2000;
    // ceil(2^30 / 1000): exact quotient for any 20-bit tick
    localparam logic [20:0] DT_RECIP       = 21'd1073742;
    localparam logic [1:0]  BLANK_COUNT    = 2'd2;
    localparam logic [7:0]  RETRY_MAX      = 8'd255;

    typedef struct packed {
        logic [22:0] ms;
        logic [9:0]  rem;
    } fes_timer_t;

    typedef struct packed {
        logic [30:0] hard_limit;
        logic [28:0] move_error;
        logic [30:0] hold_error;
        logic [15:0] move_time_ms;
        logic [15:0] hold_time_ms;
        logic [15:0] recovery_time_ms;
        logic [7:0]  max_retries;
    } fes_cfg_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] raw_error;
        logic [31:0] enc_velocity;
        logic [10:0] dt_ms;
        logic [9:0]  dt_rem;
        logic [31:0] revolution_count;
        logic [1:0]  control_mode;
        logic [31:0] target_velocity;
        logic        move_forward;
    } fes_item_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  tier;
        logic        direction;
        logic        fault_event;
        logic        recovery_event;
        logic        recovered_event;
        logic [2:0]  sup_state;
        logic [31:0] position_error;
        logic [31:0] velocity_error;
        logic [7:0]  retries_used;
        logic [22:0] error_duration_ms;
        logic        clear_accepted;
    } fes_result_t;

endpackage

// ===== src/fes_dt_split.sv =====
// ----------------------------------------------------------------------------
// Tick splitter
// Splits a tick in microseconds into whole milliseconds and a remainder.
// ----------------------------------------------------------------------------
module fes_dt_split
    import fes_pkg::*;
(
    input  logic [19:0] tick_us,
    output logic [10:0] dt_ms,
    output logic [9:0]  dt_rem
);

    logic [40:0] prod;
    logic [10:0] quo;
    logic [20:0] quo_x1000;
    logic [20:0] diff;

    // Reciprocal multiply, quotient is exact for all 20-bit values
    assign prod = 41'(tick_us) * 41'(DT_RECIP);
    assign quo  = prod[40:30];

    // quo * 1000 = quo * (1024 - 16 - 8)
    assign quo_x1000 = {quo, 10'b0} - 21'({quo, 4'b0}) - 21'({quo, 3'b0});
    assign diff      = {1'b0, tick_us} - quo_x1000;

    assign dt_ms  = quo;
    assign dt_rem = diff[9:0];

endmodule

// ===== src/fes_time_acc.sv =====
// ----------------------------------------------------------------------------
// Saturating time accumulator
// Adds a tick to a ms/remainder timer, saturating at 2^32-1 us, and flags
// when the sum is strictly above a millisecond limit.
// ----------------------------------------------------------------------------
module fes_time_acc
    import fes_pkg::*;
(
    input  fes_timer_t  acc,
    input  logic [10:0] dt_ms,
    input  logic [9:0]  dt_rem,
    input  logic [16:0] limit_ms,
    output fes_timer_t  sum,
    output logic        exceed
);

    logic [10:0] rem_sum;
    logic        carry;
    logic [10:0] rem_fix;
    logic [23:0] ms_sum;
    logic        sat;

    // Remainder with carry into milliseconds
    assign rem_sum = {1'b0, acc.rem} + {1'b0, dt_rem};
    assign carry   = (rem_sum >= US_PER_MS);
    assign rem_fix = carry ? (rem_sum - US_PER_MS) : rem_sum;
    assign ms_sum  = {1'b0, acc.ms} + 24'(dt_ms) + 24'(carry);

    // Saturate at the 32-bit microsecond ceiling
    assign sat = (ms_sum > {1'b0, TMR_MS_MAX})
              || ((ms_sum == {1'b0, TMR_MS_MAX}) && (rem_fix[9:0] > TMR_REM_MAX));

    always_comb
    begin
        if (sat)
        begin
            sum.ms  = TMR_MS_MAX;
            sum.rem = TMR_REM_MAX;
        end
        else
        begin
            sum.ms  = ms_sum[22:0];
            sum.rem = rem_fix[9:0];
        end
    end

    // us > limit * 1000
    assign exceed = (sum.ms > 23'(limit_ms))
                 || ((sum.ms == 23'(limit_ms)) && (sum.rem != 10'd0));

endmodule

// ===== src/fes_supervisor.sv =====
// ----------------------------------------------------------------------------
// Supervisor state and evaluation
// Holds the supervisor state and computes one result per item from the
// registered item, the configuration and the current state.
// ----------------------------------------------------------------------------
`include "following_error_supervisor_core_macros.svh"

module fes_supervisor
    import fes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_fire,
    input  fes_item_t   item,
    input  fes_cfg_t    cfg,
    output fes_result_t result
);

    logic [2:0]  mode_reg,     mode_next;
    logic [2:0]  saved_reg,    saved_next;
    logic        fwd_reg,      fwd_next;
    logic [31:0] setpoint_reg, setpoint_next;
    logic [31:0] baseline_reg, baseline_next;
    logic        calib_reg,    calib_next;
    fes_timer_t  err_reg,      err_next;
    fes_timer_t  rec_reg,      rec_next;
    logic [7:0]  tally_reg,    tally_next;
    logic [31:0] revs_reg,     revs_next;
    logic [1:0]  blank_reg,    blank_next;

    logic [31:0] perr;
    logic [31:0] mag;
    logic        trim;
    logic        hard_hit;
    logic [31:0] thr;
    logic [16:0] err_limit;
    logic        over_thr;
    logic [16:0] rec_limit;
    logic [1:0]  blank_eff;
    fes_timer_t  err_sum;
    logic        err_exceed;
    fes_timer_t  rec_sum;
    logic        rec_exceed;
    logic        go_fault;
    logic        go_recover;
    logic        go_idle;

    // Error relative to baseline; zero on the capturing evaluate
    assign perr = calib_reg ? 32'd0 : (item.raw_error - baseline_reg);
    assign mag  = perr[31] ? (32'd0 - perr) : perr;
    assign trim = (item.control_mode == MODE_SPEED_TRIM);

    assign hard_hit = (cfg.hard_limit != 31'd0) && (mag > {1'b0, cfg.hard_limit});

    // Threshold and debounce time for the current state
    always_comb
    begin
        priority if (mode_reg == ST_HOLDING)
        begin
            thr       = {1'b0, cfg.hold_error};
            err_limit = {1'b0, cfg.hold_time_ms};
        end
        else if (trim)
        begin
            thr       = {1'b0, cfg.move_error, 2'b00};
            err_limit = {cfg.move_time_ms, 1'b0};
        end
        else
        begin
            thr       = {3'b000, cfg.move_error};
            err_limit = {1'b0, cfg.move_time_ms};
        end
    end

    assign over_thr  = (thr != 32'd0) && (mag > thr);
    assign rec_limit = (cfg.recovery_time_ms != 16'd0) ? {1'b0, cfg.recovery_time_ms}
                                                       : RECOVERY_MS_DEF;
    assign blank_eff = (item.revolution_count != revs_reg) ? BLANK_COUNT : blank_reg;

    fes_time_acc u_err_acc (
        .acc      (err_reg),
        .dt_ms    (item.dt_ms),
        .dt_rem   (item.dt_rem),
        .limit_ms (err_limit),
        .sum      (err_sum),
        .exceed   (err_exceed)
    );

    fes_time_acc u_rec_acc (
        .acc      (rec_reg),
        .dt_ms    (item.dt_ms),
        .dt_rem   (item.dt_rem),
        .limit_ms (rec_limit),
        .sum      (rec_sum),
        .exceed   (rec_exceed)
    );

    // Command decode and state evaluation
    always_comb
    begin
        mode_next     = mode_reg;
        saved_next    = saved_reg;
        fwd_next      = fwd_reg;
        setpoint_next = setpoint_reg;
        baseline_next = baseline_reg;
        calib_next    = calib_reg;
        err_next      = err_reg;
        rec_next      = rec_reg;
        tally_next    = tally_reg;
        revs_next     = revs_reg;
        blank_next    = blank_reg;
        go_fault      = 1'b0;
        go_recover    = 1'b0;
        go_idle       = 1'b0;
        result        = '0;

        unique case (item.command)
            CMD_EVALUATE:
            begin
                if (calib_reg)
                begin
                    baseline_next = item.raw_error;
                    calib_next    = 1'b0;
                end
                result.position_error = perr;
                result.velocity_error = setpoint_reg - item.enc_velocity;
                result.direction      = fwd_reg;
                if (item.control_mode != MODE_OPEN_LOOP)
                begin
                    unique case (mode_reg)
                        ST_MOVING:
                        begin
                            if (hard_hit)
                            begin
                                go_fault = 1'b1;
                            end
                            else if (trim && (blank_eff != 2'd0))
                            begin
                                // index pulse blanking
                                revs_next  = item.revolution_count;
                                blank_next = blank_eff - 2'd1;
                                err_next   = '0;
                            end
                            else
                            begin
                                if (trim)
                                begin
                                    revs_next  = item.revolution_count;
                                    blank_next = blank_eff;
                                end
                                if (over_thr)
                                begin
                                    err_next   = err_sum;
                                    go_recover = err_exceed;
                                end
                                else
                                begin
                                    err_next = '0;
                                end
                            end
                        end
                        ST_HOLDING:
                        begin
                            if (hard_hit)
                            begin
                                go_fault = 1'b1;
                            end
                            else if (over_thr)
                            begin
                                err_next = err_sum;
                                go_fault = err_exceed;
                            end
                            else
                            begin
                                err_next = '0;
                            end
                        end
                        ST_RECOVERY:
                        begin
                            if ((cfg.move_error == 29'd0) || (mag < {3'b000, cfg.move_error}))
                            begin
                                // error back under threshold
                                mode_next              = saved_reg;
                                err_next               = '0;
                                rec_next               = '0;
                                result.direction       = 1'b0;
                                result.recovered_event = 1'b1;
                            end
                            else
                            begin
                                rec_next    = rec_sum;
                                go_fault    = rec_exceed || (tally_reg >= cfg.max_retries);
                                result.tier = TIER_RECOVER;
                            end
                        end
                        ST_FAULT:
                        begin
                            result.tier = TIER_FAULT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            CMD_BEGIN_MOVE:
            begin
                setpoint_next = item.target_velocity;
                fwd_next      = item.move_forward;
                mode_next     = ST_MOVING;
                err_next      = '0;
                tally_next    = 8'd0;
                calib_next    = 1'b1;
            end
            CMD_BEGIN_HOLD:
            begin
                mode_next  = ST_HOLDING;
                err_next   = '0;
                calib_next = 1'b1;
            end
            CMD_GO_IDLE:
            begin
                go_idle = 1'b1;
            end
            CMD_CLEAR_FAULT:
            begin
                if (mode_reg == ST_FAULT)
                begin
                    go_idle               = 1'b1;
                    result.clear_accepted = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // Fault entry
        if (go_fault)
        begin
            mode_next          = ST_FAULT;
            result.action      = ACT_HARD;
            result.tier        = TIER_FAULT;
            result.direction   = 1'b0;
            result.fault_event = 1'b1;
        end

        // Recovery entry
        if (go_recover)
        begin
            saved_next            = mode_reg;
            mode_next             = ST_RECOVERY;
            tally_next            = (tally_reg == RETRY_MAX) ? tally_reg : tally_reg + 8'd1;
            rec_next              = '0;
            result.action         = ACT_SOFT;
            result.tier           = TIER_RECOVER;
            result.direction      = 1'b0;
            result.recovery_event = 1'b1;
        end

        // Return to idle
        if (go_idle)
        begin
            mode_next     = ST_IDLE;
            setpoint_next = 32'd0;
            err_next      = '0;
            tally_next    = 8'd0;
            rec_next      = '0;
            baseline_next = 32'd0;
            calib_next    = 1'b0;
        end

        result.sup_state         = mode_next;
        result.retries_used      = tally_next;
        result.error_duration_ms = err_next.ms;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= ST_IDLE;
            saved_reg    <= ST_IDLE;
            fwd_reg      <= 1'b0;
            setpoint_reg <= 32'd0;
            baseline_reg <= 32'd0;
            calib_reg    <= 1'b0;
            err_reg      <= '0;
            rec_reg      <= '0;
            tally_reg    <= 8'd0;
            revs_reg     <= 32'd0;
            blank_reg    <= 2'd0;
        end
        else if (item_fire)
        begin
            mode_reg     <= mode_next;
            saved_reg    <= saved_next;
            fwd_reg      <= fwd_next;
            setpoint_reg <= setpoint_next;
            baseline_reg <= baseline_next;
            calib_reg    <= calib_next;
            err_reg      <= err_next;
            rec_reg      <= rec_next;
            tally_reg    <= tally_next;
            revs_reg     <= revs_next;
            blank_reg    <= blank_next;
        end
    end

    // Checks
    `FES_ASSERT_IMPL(a_err_timer_range, 1'b1, (err_reg.rem < US_PER_MS[9:0]) && (err_reg.ms <= TMR_MS_MAX), "error timer out of range")
    `FES_ASSERT_IMPL(a_blank_range, 1'b1, blank_reg != 2'd3, "blanking count above two")
    `FES_ASSERT_IMPL(a_recovery_counted, mode_reg == ST_RECOVERY, tally_reg != 8'd0, "recovery without a counted retry")

endmodule

// ===== src/following_error_supervisor_core.sv =====
// ----------------------------------------------------------------------------
// Following error supervisor core
// Supervises stepper following error: baseline capture, hard limit, debounced
// move and hold thresholds, speed-trim blanking, recovery with timeout and
// retry limit.
//
//   Channel  Handshake               Payload
//   in       in_valid / in_stall     command ... move_forward
//   out      out_valid / out_stall   action ... clear_accepted
//   cfg      cfg_we                  cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low. An accepted item is
// evaluated from the input register and its result is registered in the
// result register when that register is free or being taken.
// out_stall holds the result register; the input register still takes one
// more item, then in_stall rises.
// rst_n clears the handshake, the supervisor state and all config registers.
// ----------------------------------------------------------------------------
`include "following_error_supervisor_core_macros.svh"

module following_error_supervisor_core
    import fes_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    // Configuration
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data,

    // Input items
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         command,
    input  logic signed [31:0] cmd_position,
    input  logic signed [31:0] enc_position,
    input  logic signed [31:0] enc_velocity,
    input  logic [19:0]        tick_us,
    input  logic signed [31:0] revolution_count,
    input  logic [1:0]         control_mode,
    input  logic signed [31:0] target_velocity,
    input  logic               move_forward,

    // Result items
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         action,
    output logic [1:0]         tier,
    output logic               direction,
    output logic               fault_event,
    output logic               recovery_event,
    output logic               recovered_event,
    output logic [2:0]         sup_state,
    output logic signed [31:0] position_error,
    output logic signed [31:0] velocity_error,
    output logic [7:0]         retries_used,
    output logic [22:0]        error_duration_ms,
    output logic               clear_accepted
);

    fes_cfg_t    cfg_reg;
    logic        in_valid_reg;
    fes_item_t   item_reg;
    fes_item_t   item_next;
    logic        out_valid_reg;
    fes_result_t result_reg;
    fes_result_t result_next;
    logic        in_accept;
    logic        advance;
    logic        item_fire;
    logic [10:0] dt_ms;
    logic [9:0]  dt_rem;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HARD_LIMIT:    cfg_reg.hard_limit       <= cfg_data;
                REG_MOVE_ERROR:    cfg_reg.move_error       <= cfg_data[28:0];
                REG_HOLD_ERROR:    cfg_reg.hold_error       <= cfg_data;
                REG_MOVE_TIME:     cfg_reg.move_time_ms     <= cfg_data[15:0];
                REG_HOLD_TIME:     cfg_reg.hold_time_ms     <= cfg_data[15:0];
                REG_RECOVERY_TIME: cfg_reg.recovery_time_ms <= cfg_data[15:0];
                REG_MAX_RETRIES:   cfg_reg.max_retries      <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Handshake: the result register frees when empty or being taken
    assign advance   = !out_valid_reg || !out_stall;
    assign item_fire = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    // Tick split ahead of the input register
    fes_dt_split u_dt_split (
        .tick_us (tick_us),
        .dt_ms   (dt_ms),
        .dt_rem  (dt_rem)
    );

    always_comb
    begin
        item_next.command          = command;
        item_next.raw_error        = $unsigned(cmd_position - enc_position);
        item_next.enc_velocity     = $unsigned(enc_velocity);
        item_next.dt_ms            = dt_ms;
        item_next.dt_rem           = dt_rem;
        item_next.revolution_count = $unsigned(revolution_count);
        item_next.control_mode     = control_mode;
        item_next.target_velocity  = $unsigned(target_velocity);
        item_next.move_forward     = move_forward;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (item_fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg <= item_next;
        end
    end

    fes_supervisor u_supervisor (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_fire (item_fire),
        .item      (item_reg),
        .cfg       (cfg_reg),
        .result    (result_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (item_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign action            = result_reg.action;
    assign tier              = result_reg.tier;
    assign direction         = result_reg.direction;
    assign fault_event       = result_reg.fault_event;
    assign recovery_event    = result_reg.recovery_event;
    assign recovered_event   = result_reg.recovered_event;
    assign sup_state         = result_reg.sup_state;
    assign position_error    = $signed(result_reg.position_error);
    assign velocity_error    = $signed(result_reg.velocity_error);
    assign retries_used      = result_reg.retries_used;
    assign error_duration_ms = result_reg.error_duration_ms;
    assign clear_accepted    = result_reg.clear_accepted;

    // Checks
    `FES_ASSERT_IMPL(a_fault_event_state, out_valid_reg && result_reg.fault_event, result_reg.sup_state == ST_FAULT, "fault item without fault state")
    `FES_ASSERT_IMPL(a_recovery_event_state, out_valid_reg && result_reg.recovery_event, (result_reg.sup_state == ST_RECOVERY) && (result_reg.tier == TIER_RECOVER), "recovery item inconsistent")
    `FES_ASSERT_NEXT(a_held_item_kept, in_valid_reg && !advance, in_valid_reg, "held item dropped from input register")

endmodule

// ===== sim/following_error_supervisor_core_tb.sv =====
// ----------------------------------------------------------------------------
// Following error supervisor core testbench
// Drives command items through the valid/stall input channel, predicts each
// result with a cycle-free model of the supervisor and compares every result
// item field by field. Directed items first, then random motion sequences
// under several register settings, sender and receiver idling, and one long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module following_error_supervisor_core_tb;
    import fes_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [1:0] MODE_MONITOR = 2'd1;
    localparam logic [1:0] MODE_SPARE   = 2'd3;
    localparam logic [2:0] CMD_LAST     = 3'd7;

    localparam int QUIET_LIMIT   = 2000;
    localparam int LONG_HOLD     = 80;
    localparam int SETTLE_CYCLES = 6;
    localparam int PRINT_LIMIT   = 200;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] cmd_pos;
        logic [31:0] enc_pos;
        logic [31:0] enc_vel;
        logic [19:0] tick;
        logic [31:0] revs;
        logic [1:0]  cmode;
        logic [31:0] target;
        logic        fwd;
    } axis_item_t;

    // DUT signals
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [30:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  command = '0;
    logic [31:0] cmd_position = '0;
    logic [31:0] enc_position = '0;
    logic [31:0] enc_velocity = '0;
    logic [19:0] tick_us = '0;
    logic [31:0] revolution_count = '0;
    logic [1:0]  control_mode = '0;
    logic [31:0] target_velocity = '0;
    logic        move_forward = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  action;
    logic [1:0]  tier;
    logic        direction;
    logic        fault_event;
    logic        recovery_event;
    logic        recovered_event;
    logic [2:0]  sup_state;
    logic [31:0] position_error;
    logic [31:0] velocity_error;
    logic [7:0]  retries_used;
    logic [22:0] error_duration_ms;
    logic        clear_accepted;

    following_error_supervisor_core u_dut (
        .clk, .rst_n,
        .cfg_we, .cfg_index, .cfg_data,
        .in_valid, .in_stall,
        .command, .cmd_position, .enc_position, .enc_velocity, .tick_us,
        .revolution_count, .control_mode, .target_velocity, .move_forward,
        .out_valid, .out_stall,
        .action, .tier, .direction, .fault_event, .recovery_event,
        .recovered_event, .sup_state, .position_error, .velocity_error,
        .retries_used, .error_duration_ms, .clear_accepted
    );

    // Stimulus and scoreboard storage
    axis_item_t  pending_items[$];
    fes_result_t expected_results[$];
    axis_item_t  offer;
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          long_hold_armed = 1'b0;
    bit          long_hold_done = 1'b0;

    // Supervisor model state, reset values
    fes_cfg_t    lim = '0;
    logic [2:0]  ax_mode = ST_IDLE;
    logic [2:0]  ax_saved = ST_IDLE;
    logic        ax_fwd = 1'b0;
    logic [31:0] ax_speed = '0;
    logic [31:0] ax_base = '0;
    logic        ax_capture = 1'b0;
    logic [31:0] ax_err_us = '0;
    logic [31:0] ax_rec_us = '0;
    logic [7:0]  ax_retries = '0;
    logic [31:0] ax_revs = '0;
    logic [1:0]  ax_blank = '0;

    initial forever #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Supervisor model
    // ------------------------------------------------------------------
    function automatic logic [31:0] sat_add_us(logic [31:0] a, logic [19:0] b);
        logic [32:0] s;
        s = {1'b0, a} + 33'(b);
        return s[32] ? '1 : s[31:0];
    endfunction

    function automatic void park_axis();
        ax_mode    = ST_IDLE;
        ax_speed   = '0;
        ax_err_us  = '0;
        ax_retries = '0;
        ax_rec_us  = '0;
        ax_base    = '0;
        ax_capture = 1'b0;
    endfunction

    function automatic void enter_fault(inout fes_result_t r);
        ax_mode       = ST_FAULT;
        r.action      = ACT_HARD;
        r.tier        = TIER_FAULT;
        r.direction   = 1'b0;
        r.fault_event = 1'b1;
    endfunction

    function automatic void enter_recovery(inout fes_result_t r);
        ax_saved = ax_mode;
        ax_mode  = ST_RECOVERY;
        if (ax_retries != RETRY_MAX)
            ax_retries++;
        ax_rec_us        = '0;
        r.action         = ACT_SOFT;
        r.tier           = TIER_RECOVER;
        r.direction      = 1'b0;
        r.recovery_event = 1'b1;
    endfunction

    function automatic bit over_hard(logic [31:0] mag);
        return lim.hard_limit != '0 && mag > 32'(lim.hard_limit);
    endfunction

    // Debounce: accumulate time while over threshold, clear otherwise
    function automatic bit over_time(logic [31:0] mag, logic [31:0] thr,
                                     logic [16:0] ms, logic [19:0] dt);
        if (thr != '0 && mag > thr)
        begin
            ax_err_us = sat_add_us(ax_err_us, dt);
            return 64'(ax_err_us) > 64'(ms) * 64'(US_PER_MS);
        end
        ax_err_us = '0;
        return 1'b0;
    endfunction

    function automatic fes_result_t supervise(axis_item_t it);
        fes_result_t r;
        logic [31:0] raw, perr, mag;
        logic [16:0] limit_ms;
        r = '0;
        case (it.command)
            CMD_EVALUATE:
            begin
                raw = it.cmd_pos - it.enc_pos;
                if (ax_capture)
                begin
                    ax_base    = raw;
                    ax_capture = 1'b0;
                end
                perr = raw - ax_base;
                mag  = perr[31] ? -perr : perr;
                r.position_error = perr;
                r.velocity_error = ax_speed - it.enc_vel;
                r.direction      = ax_fwd;
                if (it.cmode != MODE_OPEN_LOOP)
                begin
                    case (ax_mode)
                        ST_MOVING:
                        begin
                            if (over_hard(mag))
                                enter_fault(r);
                            else if (it.cmode == MODE_SPEED_TRIM)
                            begin
                                // index pulse blanks this evaluate and the next
                                if (it.revs != ax_revs)
                                begin
                                    ax_revs  = it.revs;
                                    ax_blank = BLANK_COUNT;
                                end
                                if (ax_blank != '0)
                                begin
                                    ax_blank--;
                                    ax_err_us = '0;
                                end
                                else if (over_time(mag, {1'b0, lim.move_error, 2'b00},
                                                   {lim.move_time_ms, 1'b0}, it.tick))
                                    enter_recovery(r);
                            end
                            else if (over_time(mag, 32'(lim.move_error),
                                               17'(lim.move_time_ms), it.tick))
                                enter_recovery(r);
                        end
                        ST_HOLDING:
                        begin
                            if (over_hard(mag) ||
                                over_time(mag, 32'(lim.hold_error),
                                          17'(lim.hold_time_ms), it.tick))
                                enter_fault(r);
                        end
                        ST_RECOVERY:
                        begin
                            ax_rec_us = sat_add_us(ax_rec_us, it.tick);
                            limit_ms  = lim.recovery_time_ms != '0 ?
                                        17'(lim.recovery_time_ms) : RECOVERY_MS_DEF;
                            if (lim.move_error == '0 || mag < 32'(lim.move_error))
                            begin
                                ax_mode           = ax_saved;
                                ax_err_us         = '0;
                                ax_rec_us         = '0;
                                r.action          = ACT_NONE;
                                r.tier            = TIER_OBSERVE;
                                r.direction       = 1'b0;
                                r.recovered_event = 1'b1;
                            end
                            else if (64'(ax_rec_us) > 64'(limit_ms) * 64'(US_PER_MS) ||
                                     ax_retries >= lim.max_retries)
                                enter_fault(r);
                            else
                                r.tier = TIER_RECOVER;
                        end
                        ST_FAULT:
                            r.tier = TIER_FAULT;
                        default: ;
                    endcase
                end
            end
            CMD_BEGIN_MOVE:
            begin
                ax_speed   = it.target;
                ax_fwd     = it.fwd;
                ax_mode    = ST_MOVING;
                ax_err_us  = '0;
                ax_retries = '0;
                ax_capture = 1'b1;
            end
            CMD_BEGIN_HOLD:
            begin
                ax_mode    = ST_HOLDING;
                ax_err_us  = '0;
                ax_capture = 1'b1;
            end
            CMD_GO_IDLE:
                park_axis();
            CMD_CLEAR_FAULT:
            begin
                if (ax_mode == ST_FAULT)
                begin
                    park_axis();
                    r.clear_accepted = 1'b1;
                end
            end
            default: ;
        endcase
        r.sup_state         = ax_mode;
        r.retries_used      = ax_retries;
        r.error_duration_ms = 23'(ax_err_us / 32'(US_PER_MS));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [19:0] pick_tick();
        case ($urandom_range(9))
            0: return 20'd0;
            1: return 20'($urandom_range(1000000));
            2: return 20'd1000000;
            3: return 20'h7FFFF;
            default: return 20'($urandom_range(6000, 1));
        endcase
    endfunction

    // Error magnitude around the thresholds in use, random sign
    function automatic logic [31:0] pick_error(logic [31:0] thr);
        logic [31:0] m;
        case ($urandom_range(9))
            0, 1, 2: m = $urandom_range(thr);
            3, 4:    m = thr + $urandom_range((thr >> 2) + 16, 1);
            5:       m = {thr[29:0], 2'b00} + $urandom_range(2) - 1;
            6:       m = 32'(lim.hard_limit) + $urandom_range(2) - 1;
            7:       m = $urandom;
            default:
            begin
                case ($urandom_range(3))
                    0: m = 32'h8000_0000;
                    1: m = 32'h7FFF_FFFF;
                    2: m = 32'd1;
                    default: m = 32'd0;
                endcase
            end
        endcase
        return $urandom_range(1) ? -m : m;
    endfunction

    function automatic axis_item_t random_item();
        axis_item_t it;
        it.command = 3'($urandom_range(CMD_LAST));
        it.cmd_pos = $urandom;
        it.enc_pos = $urandom;
        it.enc_vel = $urandom;
        it.tick    = pick_tick();
        it.revs    = $urandom;
        it.cmode   = 2'($urandom_range(MODE_SPARE));
        it.target  = $urandom;
        it.fwd     = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic axis_item_t cmd_item(logic [2:0] code);
        axis_item_t it;
        it = random_item();
        it.command = code;
        return it;
    endfunction

    // Evaluate whose raw error is base + err
    function automatic axis_item_t eval_item(logic [31:0] base, logic [31:0] err,
                                             logic [31:0] revs, logic [1:0] cm,
                                             logic [19:0] tick);
        axis_item_t it;
        it = random_item();
        it.command = CMD_EVALUATE;
        it.enc_pos = it.cmd_pos - base - err;
        it.revs    = revs;
        it.cmode   = cm;
        it.tick    = tick;
        return it;
    endfunction

    // Mostly well-formed move/hold sequences, some noise items
    task automatic plan_random(input int count);
        int          stop_at;
        int          n;
        bit          moving;
        logic [31:0] base, revs, thr;
        logic [1:0]  cm;
        stop_at = pending_items.size() + count;
        while (pending_items.size() < stop_at)
        begin
            n = $urandom_range(99);
            if (n < 20)
                pending_items.push_back(random_item());
            else
            begin
                moving = n < 70;
                base   = $urandom;
                revs   = $urandom;
                thr    = moving ? 32'(lim.move_error) : 32'(lim.hold_error);
                case ($urandom_range(9))
                    0:          cm = MODE_OPEN_LOOP;
                    1:          cm = MODE_SPARE;
                    2, 3, 4, 5: cm = MODE_MONITOR;
                    default:    cm = MODE_SPEED_TRIM;
                endcase
                pending_items.push_back(cmd_item(moving ? CMD_BEGIN_MOVE : CMD_BEGIN_HOLD));
                pending_items.push_back(eval_item(base, '0, revs, cm, pick_tick()));
                repeat ($urandom_range(24, 3))
                begin
                    if (cm == MODE_SPEED_TRIM && $urandom_range(9) == 0)
                        revs = $urandom;
                    pending_items.push_back(eval_item(base, pick_error(thr), revs,
                        $urandom_range(9) == 0 ? 2'($urandom_range(MODE_SPARE)) : cm,
                        pick_tick()));
                end
                case ($urandom_range(4))
                    0: pending_items.push_back(cmd_item(CMD_CLEAR_FAULT));
                    1: pending_items.push_back(cmd_item(CMD_GO_IDLE));
                    2:
                    begin
                        pending_items.push_back(cmd_item(CMD_CLEAR_FAULT));
                        pending_items.push_back(cmd_item(CMD_GO_IDLE));
                    end
                    default: ;
                endcase
            end
        end
    endtask

    // One move that keeps failing and recovering until the retry count saturates
    task automatic plan_retry_run();
        logic [31:0] base, revs, thr, m;
        base = $urandom;
        revs = $urandom;
        thr  = 32'(lim.move_error);
        pending_items.push_back(cmd_item(CMD_BEGIN_MOVE));
        pending_items.push_back(eval_item(base, '0, revs, MODE_MONITOR, pick_tick()));
        repeat (int'(RETRY_MAX) + 4)
        begin
            m = thr + $urandom_range(5000, 1);
            pending_items.push_back(eval_item(base, $urandom_range(1) ? -m : m, revs,
                $urandom_range(1) ? MODE_MONITOR : MODE_SPARE, 20'($urandom_range(6000, 1))));
            m = $urandom_range(thr - 1);
            pending_items.push_back(eval_item(base, $urandom_range(1) ? -m : m, revs,
                MODE_MONITOR, pick_tick()));
        end
        // retry limit reached: a persistent error now faults
        pending_items.push_back(eval_item(base, thr + 32'd7, revs, MODE_MONITOR, 20'd100));
        pending_items.push_back(eval_item(base, thr + 32'd9, revs, MODE_MONITOR, 20'd100));
        pending_items.push_back(cmd_item(CMD_CLEAR_FAULT));
    endtask

    // Register writes, only while nothing is in flight
    task automatic program_limits(input fes_cfg_t c);
        logic [30:0] val;
        for (int r = REG_HARD_LIMIT; r <= REG_MAX_RETRIES; r++)
        begin
            case (3'(r))
                REG_HARD_LIMIT:    val = c.hard_limit;
                REG_MOVE_ERROR:    val = 31'(c.move_error);
                REG_HOLD_ERROR:    val = c.hold_error;
                REG_MOVE_TIME:     val = 31'(c.move_time_ms);
                REG_HOLD_TIME:     val = 31'(c.hold_time_ms);
                REG_RECOVERY_TIME: val = 31'(c.recovery_time_ms);
                default:           val = 31'(c.max_retries);
            endcase
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= 3'(r);
            cfg_data  <= val;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        lim = c;
    endtask

    // Sampled on the falling edge so the driver's updates have settled
    task automatic wait_drained();
        @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got_v,
                               input logic [31:0] want_v);
        if (got_v !== want_v)
            report_mismatch($sformatf("%s got 0x%08h expected 0x%08h", name, got_v, want_v));
    endtask

    // ------------------------------------------------------------------
    // Input driver: next item only once the current one is taken
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_items
        bit take_next;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(supervise(offer));
                take_next = 1'b1;
            end
            else
                take_next = !in_valid;
            if (take_next)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offer = pending_items.pop_front();
                    in_valid         <= 1'b1;
                    command          <= offer.command;
                    cmd_position     <= offer.cmd_pos;
                    enc_position     <= offer.enc_pos;
                    enc_velocity     <= offer.enc_vel;
                    tick_us          <= offer.tick;
                    revolution_count <= offer.revs;
                    control_mode     <= offer.cmode;
                    target_velocity  <= offer.target;
                    move_forward     <= offer.fwd;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver stall
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        fes_result_t got, want;
        int          hold_left;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = {action, tier, direction, fault_event, recovery_event,
                       recovered_event, sup_state, position_error, velocity_error,
                       retries_used, error_duration_ms, clear_accepted};
                if (expected_results.size() == 0)
                    report_mismatch("result item with nothing expected");
                else
                begin
                    want = expected_results.pop_front();
                    check_field("action", 32'(got.action), 32'(want.action));
                    check_field("tier", 32'(got.tier), 32'(want.tier));
                    check_field("direction", 32'(got.direction), 32'(want.direction));
                    check_field("fault_event", 32'(got.fault_event), 32'(want.fault_event));
                    check_field("recovery_event", 32'(got.recovery_event),
                                32'(want.recovery_event));
                    check_field("recovered_event", 32'(got.recovered_event),
                                32'(want.recovered_event));
                    check_field("sup_state", 32'(got.sup_state), 32'(want.sup_state));
                    check_field("position_error", got.position_error, want.position_error);
                    check_field("velocity_error", got.velocity_error, want.velocity_error);
                    check_field("retries_used", 32'(got.retries_used),
                                32'(want.retries_used));
                    check_field("error_duration_ms", 32'(got.error_duration_ms),
                                32'(want.error_duration_ms));
                    check_field("clear_accepted", 32'(got.clear_accepted),
                                32'(want.clear_accepted));
                end
            end
            // one long hold-off once armed, random stall otherwise
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (long_hold_armed && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD - 1;
                out_stall     <= 1'b1;
            end
            else
                out_stall <= $urandom_range(99) < recv_stall_pct;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no handshake on either channel for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watchdog
        int quiet_cycles;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : run_test
        fes_cfg_t   c;
        axis_item_t it;
        logic [31:0] base;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 20;
        recv_stall_pct = 54;

        // Directed: thresholds small enough to walk through every state
        c = '{hard_limit: 31'd1000000, move_error: 29'd1000, hold_error: 31'd500,
              move_time_ms: 16'd2, hold_time_ms: 16'd3, recovery_time_ms: 16'd0,
              max_retries: 8'd2};
        program_limits(c);
        base = 32'h0001_2345;

        // open loop evaluate in idle with extreme operands
        it = random_item();
        it.command = CMD_EVALUATE;
        it.cmd_pos = 32'h7FFF_FFFF;
        it.enc_pos = 32'h8000_0000;
        it.enc_vel = 32'h8000_0000;
        it.tick    = 20'd1000000;
        it.revs    = 32'h7FFF_FFFF;
        it.cmode   = MODE_OPEN_LOOP;
        pending_items.push_back(it);
        it = cmd_item(CMD_BEGIN_MOVE);
        it.target = 32'h8000_0000;
        it.fwd    = 1'b1;
        pending_items.push_back(it);
        // baseline capture, then small error, open loop observe
        pending_items.push_back(eval_item(base, 32'd0, 32'd0, MODE_MONITOR, 20'h7FFFF));
        pending_items.push_back(eval_item(base, 32'd10, 32'd0, MODE_SPARE, 20'd100));
        pending_items.push_back(eval_item(base, 32'd900000, 32'd0, MODE_OPEN_LOOP, 20'd1000));
        // move threshold debounce into recovery
        pending_items.push_back(eval_item(base, -32'd1500, 32'd0, MODE_MONITOR, 20'd1500));
        pending_items.push_back(eval_item(base, 32'd1500, 32'd0, MODE_MONITOR, 20'd1500));
        pending_items.push_back(eval_item(base, 32'd2000, 32'd0, MODE_MONITOR, 20'd1000));
        pending_items.push_back(eval_item(base, 32'd5, 32'd0, MODE_MONITOR, 20'd1000));
        // index pulse blanks two speed-trim evaluates, then 4x threshold
        pending_items.push_back(eval_item(base, 32'd9000, 32'd5, MODE_SPEED_TRIM, 20'd9000));
        pending_items.push_back(eval_item(base, 32'd9000, 32'd5, MODE_SPEED_TRIM, 20'd9000));
        pending_items.push_back(eval_item(base, 32'd4500, 32'd5, MODE_SPEED_TRIM, 20'd5000));
        // retry limit reached in recovery: fault
        pending_items.push_back(eval_item(base, -32'd3000, 32'd5, MODE_MONITOR, 20'd1000));
        pending_items.push_back(eval_item(base, 32'd3000, 32'd5, MODE_MONITOR, 20'd1000));
        pending_items.push_back(cmd_item(CMD_CLEAR_FAULT));
        pending_items.push_back(cmd_item(CMD_CLEAR_FAULT));
        // hold threshold debounce into fault
        pending_items.push_back(cmd_item(CMD_BEGIN_HOLD));
        pending_items.push_back(eval_item(base, 32'd0, 32'd5, MODE_MONITOR, 20'd10));
        pending_items.push_back(eval_item(base, 32'd600, 32'd5, MODE_MONITOR, 20'd2000));
        pending_items.push_back(eval_item(base, 32'd600, 32'd5, MODE_MONITOR, 20'd1500));
        // most negative error, magnitude 2^31, over the hard limit
        pending_items.push_back(cmd_item(CMD_BEGIN_HOLD));
        pending_items.push_back(eval_item(base, 32'd0, 32'd5, MODE_MONITOR, 20'd10));
        pending_items.push_back(eval_item(base, 32'h8000_0000, 32'd5, MODE_MONITOR, 20'd10));
        pending_items.push_back(cmd_item(CMD_GO_IDLE));
        // unused command codes
        for (int k = int'(CMD_CLEAR_FAULT) + 1; k <= int'(CMD_LAST); k++)
            pending_items.push_back(cmd_item(3'(k)));
        wait_drained();

        // Random, moderate thresholds
        c.hard_limit       = $urandom_range(3) == 0 ? 31'd0 :
                             31'($urandom_range(2000000, 20000));
        c.move_error       = 29'($urandom_range(5000, 50));
        c.hold_error       = 31'($urandom_range(3000));
        c.move_time_ms     = 16'($urandom_range(12));
        c.hold_time_ms     = 16'($urandom_range(12));
        c.recovery_time_ms = 16'($urandom_range(15));
        c.max_retries      = 8'($urandom_range(4));
        program_limits(c);
        plan_random(70);
        wait_drained();

        // Extreme register values, sender idles more than receiver
        send_idle_pct  = 54;
        recv_stall_pct = 20;
        c = '{hard_limit: 31'd0, move_error: 29'h1FFF_FFFF, hold_error: 31'h7FFF_FFFF,
              move_time_ms: 16'd0, hold_time_ms: 16'hFFFF, recovery_time_ms: 16'hFFFF,
              max_retries: 8'hFF};
        program_limits(c);
        plan_random(70);
        wait_drained();

        // No idling; escalation disabled, tight hold; long receiver hold-off
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        c = '{hard_limit: 31'h7FFF_FFFF, move_error: 29'd0, hold_error: 31'd1,
              move_time_ms: 16'hFFFF, hold_time_ms: 16'd0, recovery_time_ms: 16'd1,
              max_retries: 8'd1};
        program_limits(c);
        plan_random(50);
        long_hold_armed = 1'b1;
        wait_drained();

        // Another random setting, then the retry saturation run
        c.hard_limit       = 31'($urandom_range(200000, 1));
        c.move_error       = 29'($urandom_range(3000, 20));
        c.hold_error       = 31'($urandom_range(3000, 1));
        c.move_time_ms     = 16'($urandom_range(8));
        c.hold_time_ms     = 16'($urandom_range(8));
        c.recovery_time_ms = 16'($urandom_range(10));
        c.max_retries      = 8'($urandom_range(3));
        program_limits(c);
        plan_random(40);
        wait_drained();

        c = '{hard_limit: 31'd0, move_error: 29'd300, hold_error: 31'd0,
              move_time_ms: 16'd0, hold_time_ms: 16'd0, recovery_time_ms: 16'hFFFF,
              max_retries: 8'hFF};
        program_limits(c);
        plan_retry_run();
        wait_drained();

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/fes_pkg.sv
src/fes_dt_split.sv
src/fes_time_acc.sv
src/fes_supervisor.sv
src/following_error_supervisor_core.sv
sim/following_error_supervisor_core_tb.sv
